// File: rtl/page_frame_allocator_refcount_top_assert.svh
// ---------------------------------------------------------------------------
// Page frame allocator assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page frame allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define PFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page frame allocator: next-cycle check failed");

`endif

// File: rtl/pfa_pkg.sv
// ---------------------------------------------------------------------------
// Page frame allocator package
// Sizes, operation and status codes, and controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int PAGE_COUNT     = 32768;
  localparam int PAGE_BITS      = 15;
  localparam int DEPTH_BITS     = PAGE_BITS + 1;
  localparam int COUNT_BITS     = 16;
  localparam int MODE_BITS      = 3;
  localparam int STATUS_BITS    = 3;
  localparam int FIRST_BITS     = 15;
  localparam int LIMIT_BITS     = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL  = DEPTH_BITS'(PAGE_COUNT);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(PAGE_COUNT);
  localparam logic [LIMIT_BITS-1:0] LIMIT_CLAMP = LIMIT_BITS'(PAGE_COUNT);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT = 1'd1;

  localparam logic [MODE_BITS-1:0] MODE_INIT  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ALLOC = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_FREE  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_SHARE = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_QUERY = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_ZERO  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_SAT   = 3'd4;

  typedef struct packed {
    logic capture;     // latch the request and issue memory reads
    logic sweep_en;    // clear one count entry per cycle
    logic sweep_init;  // also fill the free stack during the sweep
    logic commit;      // apply writes and load the result
  } pfa_cmd_t;

  typedef struct packed {
    logic init_req;    // incoming request is an initialize
    logic sweep_last;  // sweep is at the final entry
  } pfa_stat_t;

endpackage

`default_nettype wire

// File: rtl/pfa_if.sv
// ---------------------------------------------------------------------------
// Page frame allocator channel interfaces
// Valid/ready request and result channels with their payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface pfa_in_if;
  logic                           valid;
  logic                           ready;
  logic [pfa_pkg::MODE_BITS-1:0]  mode;
  logic [pfa_pkg::PAGE_BITS-1:0]  page_number;

  modport source (output valid, output mode, output page_number, input ready);
  modport sink   (input valid, input mode, input page_number, output ready);
endinterface

interface pfa_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfa_pkg::PAGE_BITS-1:0]   page_out;
  logic [pfa_pkg::COUNT_BITS-1:0]  ref_count;
  logic [pfa_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, output page_out, output ref_count, output status,
                  input ready);
  modport sink   (input valid, input page_out, input ref_count, input status,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/page_frame_allocator_refcount_top.sv
// ---------------------------------------------------------------------------
// Page frame allocator with reference counts
// LIFO free stack of page frames plus a reference count per frame.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake         Payload
//  in_ch    in   valid/ready       mode, page_number
//  out_ch   out  valid/ready       page_out, ref_count, status
//  cfg_*    in   cfg_we only       cfg_index, cfg_data
//
//  Alloc, free, share, query: a memory fetch step, then an update and result
//  load step; the fetch is the registered read of the count memory.
//  Initialize: a sweep between fetch and update, one count entry cleared per cycle.
//  After reset a clearing pass over all 32768 entries runs before in_ch.ready rises.
//  A stalled result holds the block in its update step until taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "page_frame_allocator_refcount_top_assert.svh"

module page_frame_allocator_refcount_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  pfa_in_if.sink                                    in_ch,
  pfa_out_if.source                                 out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [pfa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  pfa_pkg::pfa_cmd_t  cmd;
  pfa_pkg::pfa_stat_t stat;

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_ch.mode),
    .in_page    (in_ch.page_number),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_page   (out_ch.page_out),
    .res_count  (out_ch.ref_count),
    .res_status (out_ch.status)
  );

  // One transaction at a time: busy straight after an accept
  `PFA_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // A commit always presents a result in the next cycle
  `PFA_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_ch.valid)
  // Sweep and commit share the memory write ports and must not overlap
  `PFA_ASSERT_NOW(a_sweep_commit_excl, cmd.sweep_en, !cmd.commit && !cmd.capture)

endmodule

`default_nettype wire

// File: rtl/pfa_ctrl.sv
// ---------------------------------------------------------------------------
// Page frame allocator controller
// Sequences reset clearing, initialize sweeps and fetch-then-update operations.
// ---------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire pfa_pkg::pfa_stat_t stat,
  output pfa_pkg::pfa_cmd_t       cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep_en = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = stat.init_req ? S_SWEEP : S_EXEC;
        end
      end
      S_SWEEP: begin
        cmd.sweep_en   = 1'b1;
        cmd.sweep_init = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.commit | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pfa_dp.sv
// ---------------------------------------------------------------------------
// Page frame allocator datapath
// Count and free stack memories, pool registers, stack depth and result.
// ---------------------------------------------------------------------------
`default_nettype none

module pfa_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire pfa_pkg::pfa_cmd_t                      cmd,
  output pfa_pkg::pfa_stat_t                          stat,
  input  wire logic [pfa_pkg::MODE_BITS-1:0]          in_mode,
  input  wire logic [pfa_pkg::PAGE_BITS-1:0]          in_page,
  input  wire logic                                   cfg_we,
  input  wire logic [pfa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output logic      [pfa_pkg::PAGE_BITS-1:0]          res_page,
  output logic      [pfa_pkg::COUNT_BITS-1:0]         res_count,
  output logic      [pfa_pkg::STATUS_BITS-1:0]        res_status
);

  localparam int PB = pfa_pkg::PAGE_BITS;
  localparam int DB = pfa_pkg::DEPTH_BITS;
  localparam int CB = pfa_pkg::COUNT_BITS;

  logic [CB-1:0] count_mem_r [pfa_pkg::PAGE_COUNT];
  logic [PB-1:0] stack_mem_r [pfa_pkg::PAGE_COUNT];

  logic [pfa_pkg::FIRST_BITS-1:0] first_r;
  logic [pfa_pkg::LIMIT_BITS-1:0] limit_r;
  logic [DB-1:0]                  depth_r, depth_nxt;
  logic [PB-1:0]                  sweep_r;
  logic [pfa_pkg::MODE_BITS-1:0]  mode_r;
  logic [PB-1:0]                  page_r;
  logic [CB-1:0]                  cnt_q_r;
  logic [PB-1:0]                  stk_q_r;

  logic [pfa_pkg::LIMIT_BITS-1:0] lim_clamp;
  logic [DB-1:0]                  win_size;
  logic                           in_win;
  logic                           sweep_in_win;
  logic [CB-1:0]                  cnt_dec, cnt_inc;

  logic [PB-1:0]                  ex_page;
  logic [CB-1:0]                  ex_count;
  logic [pfa_pkg::STATUS_BITS-1:0] ex_status;
  logic                           ex_cnt_we, ex_stk_we;
  logic [PB-1:0]                  ex_cnt_wa;
  logic [CB-1:0]                  ex_cnt_wd;

  logic                           cnt_we, stk_we;
  logic [PB-1:0]                  cnt_wa, stk_wa, stk_wd;
  logic [CB-1:0]                  cnt_wd;

  assign stat.init_req   = (in_mode == pfa_pkg::MODE_INIT);
  assign stat.sweep_last = (sweep_r == {PB{1'b1}});

  assign lim_clamp = (limit_r > pfa_pkg::LIMIT_CLAMP) ? pfa_pkg::LIMIT_CLAMP : limit_r;
  assign win_size  = (lim_clamp > {1'b0, first_r}) ? DB'(lim_clamp - {1'b0, first_r})
                                                   : '0;
  assign in_win       = (page_r >= first_r) && ({1'b0, page_r} < limit_r);
  assign sweep_in_win = (sweep_r >= first_r) && ({1'b0, sweep_r} < lim_clamp);
  assign cnt_dec      = cnt_q_r - 1'b1;
  assign cnt_inc      = cnt_q_r + 1'b1;

  // Operation outcome from the captured request and the fetched entries
  always_comb begin
    ex_page   = page_r;
    ex_count  = '0;
    ex_status = pfa_pkg::ST_OK;
    depth_nxt = depth_r;
    ex_cnt_we = 1'b0;
    ex_cnt_wa = page_r;
    ex_cnt_wd = '0;
    ex_stk_we = 1'b0;
    unique case (mode_r)
      pfa_pkg::MODE_INIT: begin
        ex_page   = '0;
        depth_nxt = win_size;
      end
      pfa_pkg::MODE_ALLOC: begin
        if (depth_r == '0) begin
          ex_page   = '0;
          ex_status = pfa_pkg::ST_EMPTY;
        end else begin
          depth_nxt = depth_r - 1'b1;
          ex_page   = stk_q_r;
          ex_count  = CB'(1);
          ex_cnt_we = 1'b1;
          ex_cnt_wa = stk_q_r;
          ex_cnt_wd = CB'(1);
        end
      end
      pfa_pkg::MODE_FREE: begin
        if (!in_win) begin
          ex_status = pfa_pkg::ST_RANGE;
        end else if (cnt_q_r == '0) begin
          ex_status = pfa_pkg::ST_ZERO;
        end else begin
          ex_count  = cnt_dec;
          ex_cnt_we = 1'b1;
          ex_cnt_wd = cnt_dec;
          // return the frame to the pool; drop the push on a full stack
          if (cnt_dec == '0 && depth_r != pfa_pkg::DEPTH_FULL) begin
            ex_stk_we = 1'b1;
            depth_nxt = depth_r + 1'b1;
          end
        end
      end
      pfa_pkg::MODE_SHARE: begin
        if (!in_win) begin
          ex_status = pfa_pkg::ST_RANGE;
        end else if (cnt_q_r == pfa_pkg::COUNT_MAX) begin
          ex_count  = cnt_q_r;
          ex_status = pfa_pkg::ST_SAT;
        end else begin
          ex_count  = cnt_inc;
          ex_cnt_we = 1'b1;
          ex_cnt_wd = cnt_inc;
        end
      end
      pfa_pkg::MODE_QUERY: begin
        if (!in_win) begin
          ex_status = pfa_pkg::ST_RANGE;
        end else begin
          ex_count = cnt_q_r;
        end
      end
      default: begin
        ex_status = pfa_pkg::ST_RANGE;
      end
    endcase
  end

  // Single write port per memory: sweep or commit
  always_comb begin
    if (cmd.sweep_en) begin
      cnt_we = 1'b1;
      cnt_wa = sweep_r;
      cnt_wd = '0;
      stk_we = cmd.sweep_init & sweep_in_win;
      stk_wa = PB'(sweep_r - first_r);
      stk_wd = sweep_r;
    end else begin
      cnt_we = cmd.commit & ex_cnt_we;
      cnt_wa = ex_cnt_wa;
      cnt_wd = ex_cnt_wd;
      stk_we = cmd.commit & ex_stk_we;
      stk_wa = depth_r[PB-1:0];
      stk_wd = page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem_r[cnt_wa] <= cnt_wd;
    end
    if (stk_we) begin
      stack_mem_r[stk_wa] <= stk_wd;
    end
    if (cmd.capture) begin
      cnt_q_r <= count_mem_r[in_page];
      stk_q_r <= stack_mem_r[PB'(depth_r - 1'b1)];
      mode_r  <= in_mode;
      page_r  <= in_page;
    end
    if (cmd.commit) begin
      res_page   <= ex_page;
      res_count  <= ex_count;
      res_status <= ex_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      limit_r <= pfa_pkg::LIMIT_RESET;
      depth_r <= '0;
      sweep_r <= '0;
    end else begin
      if (cfg_we && cfg_index == pfa_pkg::CFG_FIRST) begin
        first_r <= cfg_data[pfa_pkg::FIRST_BITS-1:0];
      end
      if (cfg_we && cfg_index == pfa_pkg::CFG_LIMIT) begin
        limit_r <= cfg_data[pfa_pkg::LIMIT_BITS-1:0];
      end
      if (cmd.sweep_en) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.commit) begin
        depth_r <= depth_nxt;
      end
    end
  end

endmodule

`default_nettype wire
